>>> design/lcs_pkg.sv
// Link connection supervisor: shared package.
// Link and engine state codes, opcodes, action codes and default sizes.
// No dependencies.
package lcs_pkg;

	localparam int NumSlotsDef    = 16;
	localparam int AttemptBitsDef = 8;

	typedef enum logic [3:0] {
		LS_DOWN          = 4'd0,
		LS_DISABLED      = 4'd1,
		LS_CONNECTING    = 4'd2,
		LS_DISCONNECTING = 4'd3,
		LS_CONNPEND      = 4'd4,
		LS_DISCPEND      = 4'd5,
		LS_UP            = 4'd6,
		LS_RECONNPEND    = 4'd7,
		LS_RECONNECTING  = 4'd8,
		LS_FAILED        = 4'd9,
		LS_DELETED       = 4'd10
	} link_st_t;

	localparam logic [2:0] EN_STOPPED   = 3'd0;
	localparam logic [2:0] EN_STARTING  = 3'd1;
	localparam logic [2:0] EN_RUNNING   = 3'd2;
	localparam logic [2:0] EN_STOPPING  = 3'd3;
	localparam logic [2:0] EN_STARTPEND = 3'd4;
	localparam logic [2:0] EN_STOPPEND  = 3'd5;

	localparam logic [3:0] OP_START    = 4'd0;
	localparam logic [3:0] OP_STOP     = 4'd1;
	localparam logic [3:0] OP_UP       = 4'd2;
	localparam logic [3:0] OP_DOWN     = 4'd3;
	localparam logic [3:0] OP_CONN     = 4'd4;
	localparam logic [3:0] OP_DISC     = 4'd5;
	localparam logic [3:0] OP_RECONNING = 4'd6;
	localparam logic [3:0] OP_RECONN   = 4'd7;
	localparam logic [3:0] OP_TIMER    = 4'd8;
	localparam logic [3:0] OP_DELETE   = 4'd9;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_CONN   = 3'd1;
	localparam logic [2:0] ACT_DISC   = 3'd2;
	localparam logic [2:0] ACT_RECNOW = 3'd3;
	localparam logic [2:0] ACT_RECDLY = 3'd4;

	typedef enum logic [2:0] {
		CAT_DOWN, CAT_DISABLED, CAT_TRANS, CAT_UP, CAT_RECONN, CAT_FAILED, CAT_NONE
	} cat_t;

	function automatic logic is_trans(input logic [3:0] s);
		return (s >= LS_CONNECTING) && (s <= LS_DISCPEND);
	endfunction

	function automatic cat_t cat_of(input logic [3:0] s);
		cat_t c;
		c = CAT_NONE;
		if (s == LS_DOWN)
			c = CAT_DOWN;
		else if (s == LS_DISABLED)
			c = CAT_DISABLED;
		else if (is_trans(s))
			c = CAT_TRANS;
		else if (s == LS_UP)
			c = CAT_UP;
		else if (s == LS_RECONNPEND || s == LS_RECONNECTING)
			c = CAT_RECONN;
		else if (s == LS_FAILED)
			c = CAT_FAILED;
		return c;
	endfunction

	// outcome of one slot event, handed from the event unit to the sequencer
	typedef struct packed {
		logic [3:0] next;
		logic [2:0] act;
		logic       en;
		logic       clr_att;
		logic       inc_att;
	} ev_res_t;

endpackage

>>> design/lcs_event_unit.sv
// Link connection supervisor: shared slot event unit.
// Combinational next-state, action and enable update of one slot.
// Depends on lcs_pkg.
module lcs_event_unit import lcs_pkg::*; (
	input  logic [3:0] op,
	input  logic       flag,
	input  logic [3:0] prev,
	input  logic       en_in,
	input  logic       running,
	output ev_res_t    res
);

	always_comb begin
		res.next    = prev;
		res.act     = ACT_NONE;
		res.en      = en_in;
		res.clr_att = 1'b0;
		res.inc_att = 1'b0;
		case (op)
			OP_UP: begin
				if (flag)
					res.en = 1'b1;
				if (prev == LS_DISABLED || prev == LS_DOWN || prev == LS_FAILED) begin
					if (running) begin
						res.next = LS_CONNECTING;
						res.act  = ACT_CONN;
					end else
						res.next = LS_DOWN;
				end else if (prev == LS_DISCONNECTING) begin
					if (running && res.en)
						res.next = LS_CONNPEND;
				end else if (prev == LS_DISCPEND) begin
					if (res.en)
						res.next = LS_CONNECTING;
				end
			end
			OP_DOWN: begin
				if (flag)
					res.en = 1'b0;
				if (prev == LS_DOWN) begin
					if (!res.en)
						res.next = LS_DISABLED;
				end else if (prev == LS_UP || prev == LS_RECONNPEND ||
						prev == LS_RECONNECTING) begin
					res.next = LS_DISCONNECTING;
					res.act  = ACT_DISC;
				end else if (prev == LS_CONNECTING)
					res.next = LS_DISCPEND;
				else if (prev == LS_CONNPEND)
					res.next = LS_DISCONNECTING;
			end
			OP_CONN: begin
				if (prev == LS_CONNECTING || prev == LS_RECONNPEND ||
						prev == LS_RECONNECTING || prev == LS_UP) begin
					res.next    = LS_UP;
					res.clr_att = 1'b1;
				end else if (prev == LS_DISCPEND) begin
					res.next    = LS_DISCONNECTING;
					res.act     = ACT_DISC;
					res.clr_att = 1'b1;
				end
			end
			OP_DISC: begin
				if (prev == LS_CONNECTING || prev == LS_DISCPEND || prev == LS_RECONNPEND ||
						prev == LS_RECONNECTING || prev == LS_UP) begin
					res.next    = en_in ? LS_FAILED : LS_DISABLED;
					res.clr_att = 1'b1;
				end else if (prev == LS_DISCONNECTING) begin
					res.next    = en_in ? LS_DOWN : LS_DISABLED;
					res.clr_att = 1'b1;
				end else if (prev == LS_CONNPEND) begin
					if (en_in) begin
						res.next = LS_CONNECTING;
						res.act  = ACT_CONN;
					end else
						res.next = LS_DISABLED;
					res.clr_att = 1'b1;
				end
			end
			OP_RECONNING: begin
				if (prev == LS_UP)
					res.next = LS_CONNECTING;
			end
			OP_RECONN: begin
				if (prev == LS_CONNECTING || prev == LS_RECONNECTING || prev == LS_UP) begin
					res.next    = LS_RECONNPEND;
					res.act     = flag ? ACT_RECNOW : ACT_RECDLY;
					res.inc_att = 1'b1;
				end else if (prev == LS_DISCPEND)
					res.act = ACT_DISC;
			end
			OP_TIMER: begin
				if (prev == LS_RECONNPEND) begin
					res.next = LS_RECONNECTING;
					res.act  = ACT_CONN;
				end
			end
			OP_DELETE:
				res.next = LS_DELETED;
			default: ;
		endcase
	end

endmodule

>>> design/link_connection_supervisor.sv
// Link connection supervisor: top level with slot table, counters, engine and sequencer.
// Uses lcs_pkg and lcs_event_unit.
//
// channel | direction | handshake     | payload
// in      | input     | valid / stall | opcode, slot, flag
// out     | output    | out_valid / out_stall | out_slot, link_status, action, attempts,
//         |           |               | engine_mode, last
//
// Each beat: latch in ST_IDLE, read-modify-write the slot in ST_EXEC, present the result
// in ST_OUT, held while out_stall is high. A fan-out runs NUM_SLOTS slots in order.
// Every step goes through the single event unit; no input is taken until the last
// result has left. Reset puts slots and counters at all-down and stops the engine.
module link_connection_supervisor import lcs_pkg::*; #(
	parameter int NUM_SLOTS    = NumSlotsDef,
	parameter int ATTEMPT_BITS = AttemptBitsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       stall,
	input  logic [3:0] opcode,
	input  logic [3:0] slot,
	input  logic       flag,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] out_slot,
	output logic [3:0] link_status,
	output logic [2:0] action,
	output logic [7:0] attempts,
	output logic [2:0] engine_mode,
	output logic       last
);

	localparam int SW = $clog2(NUM_SLOTS + 1);
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = SW;
	localparam logic [ATTEMPT_BITS-1:0] AMAX = '1;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} seq_t;

	seq_t seq_q;
	logic [3:0] op_q;
	logic [3:0] slot_q;
	logic       flag_q;
	logic [1:0] sweep_q;
	logic       in_sweep_q;
	logic [SW-1:0] idx_q;

	logic [3:0]              st_q  [NUM_SLOTS];
	logic                    en_q  [NUM_SLOTS];
	logic [ATTEMPT_BITS-1:0] att_q [NUM_SLOTS];

	logic [2:0] eng_q;
	logic [CW-1:0] c_down_q, c_dis_q, c_tr_q, c_up_q, c_rc_q, c_fail_q;

	// current step operands
	logic [3:0]    cur_op;
	logic          cur_flag;
	logic [SW-1:0] cur_slot_w;
	logic          cur_valid_slot;
	logic [IW-1:0] cur_idx;
	logic [3:0]    prev;
	logic          running;
	ev_res_t       res;

	always_comb begin
		if (in_sweep_q) begin
			cur_op     = (sweep_q == 2'd1) ? OP_UP : OP_DOWN;
			cur_flag   = 1'b0;
			cur_slot_w = idx_q;
		end else begin
			cur_op     = op_q;
			cur_flag   = flag_q;
			cur_slot_w = SW'(slot_q);
		end
		cur_valid_slot = in_sweep_q || (32'(slot_q) < NUM_SLOTS);
		cur_idx = cur_valid_slot ? cur_slot_w[IW-1:0] : '0;
		prev    = st_q[cur_idx];
		running = (eng_q == EN_STARTING) || (eng_q == EN_RUNNING);
	end

	lcs_event_unit u_ev (
		.op     (cur_op),
		.flag   (cur_flag),
		.prev   (prev),
		.en_in  (en_q[cur_idx]),
		.running(running),
		.res    (res)
	);

	logic is_slot_ev;
	assign is_slot_ev = in_sweep_q ||
		(cur_valid_slot && op_q >= OP_UP && op_q <= OP_DELETE);

	// counter update and engine move
	logic [CW-1:0] nd, ndi, nt, nu, nr, nf;
	logic [2:0]    eng_n;
	logic [1:0]    req_n;
	logic          moved, was_low, was_high;
	cat_t          cp, cn;

	always_comb begin
		nd = c_down_q; ndi = c_dis_q; nt = c_tr_q;
		nu = c_up_q;   nr = c_rc_q;   nf = c_fail_q;
		eng_n = eng_q;
		req_n = 2'd0;
		cp = cat_of(prev);
		cn = cat_of(res.next);
		was_low  = (prev == LS_DOWN) || is_trans(prev);
		was_high = (prev == LS_UP) || is_trans(prev);
		moved = is_slot_ev && (prev != res.next) &&
			!(is_trans(prev) && is_trans(res.next));
		if (!is_slot_ev) begin
			if (op_q == OP_START) begin
				if (eng_q == EN_STOPPED) begin
					eng_n = EN_STARTING; req_n = 2'd1;
				end else if (eng_q == EN_STOPPING)
					eng_n = EN_STARTPEND;
			end else if (op_q == OP_STOP) begin
				if (eng_q == EN_RUNNING) begin
					eng_n = EN_STOPPING; req_n = 2'd2;
				end else if (eng_q == EN_STARTING)
					eng_n = EN_STOPPEND;
			end
		end else if (moved) begin
			case (cp)
				CAT_DOWN:     nd  = nd - 1'b1;
				CAT_DISABLED: ndi = ndi - 1'b1;
				CAT_TRANS:    nt  = nt - 1'b1;
				CAT_UP:       nu  = nu - 1'b1;
				CAT_RECONN:   nr  = nr - 1'b1;
				CAT_FAILED:   nf  = nf - 1'b1;
				default: ;
			endcase
			case (cn)
				CAT_DOWN:     nd  = nd + 1'b1;
				CAT_DISABLED: ndi = ndi + 1'b1;
				CAT_TRANS:    nt  = nt + 1'b1;
				CAT_UP:       nu  = nu + 1'b1;
				CAT_RECONN:   nr  = nr + 1'b1;
				CAT_FAILED:   nf  = nf + 1'b1;
				default: ;
			endcase
			case (eng_q)
				EN_STARTING:
					if (was_low && (nd + nt) == '0) eng_n = EN_RUNNING;
				EN_STOPPEND:
					if (was_low && (nd + nt) == '0) begin
						eng_n = EN_STOPPING; req_n = 2'd2;
					end
				EN_STOPPING:
					if (was_high && (nu + nt) == '0) eng_n = EN_STOPPED;
				EN_STARTPEND:
					if (was_high && (nu + nt) == '0) begin
						eng_n = EN_STARTING; req_n = 2'd1;
					end
				default: ;
			endcase
		end
	end

	logic [ATTEMPT_BITS-1:0] att_n;
	always_comb begin
		att_n = att_q[cur_idx];
		if (res.clr_att)
			att_n = '0;
		else if (res.inc_att && att_n != AMAX)
			att_n = att_n + 1'b1;
	end

	logic last_step;
	assign last_step = in_sweep_q ? (idx_q == SW'(NUM_SLOTS - 1)) : (req_n == 2'd0);

	assign stall = (seq_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= ST_IDLE;
			sweep_q    <= 2'd0;
			in_sweep_q <= 1'b0;
			idx_q      <= '0;
			out_valid  <= 1'b0;
			eng_q      <= EN_STOPPED;
			c_down_q   <= CW'(NUM_SLOTS);
			c_dis_q    <= '0;
			c_tr_q     <= '0;
			c_up_q     <= '0;
			c_rc_q     <= '0;
			c_fail_q   <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				st_q[i]  <= LS_DOWN;
				en_q[i]  <= 1'b0;
				att_q[i] <= '0;
			end
		end else begin
			unique case (seq_q)
				ST_IDLE: begin
					if (valid) begin
						op_q       <= opcode;
						slot_q     <= slot;
						flag_q     <= flag;
						in_sweep_q <= 1'b0;
						seq_q      <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_slot_ev) begin
						st_q[cur_idx]  <= res.next;
						en_q[cur_idx]  <= res.en;
						att_q[cur_idx] <= att_n;
					end
					c_down_q <= nd; c_dis_q <= ndi; c_tr_q <= nt;
					c_up_q   <= nu; c_rc_q  <= nr;  c_fail_q <= nf;
					eng_q    <= eng_n;
					if (!in_sweep_q)
						sweep_q <= req_n;
					out_valid   <= 1'b1;
					out_slot    <= in_sweep_q ? 4'(idx_q) : slot_q;
					link_status <= cur_valid_slot ?
						(is_slot_ev ? res.next : prev) : LS_DELETED;
					action      <= is_slot_ev ? res.act : ACT_NONE;
					attempts    <= cur_valid_slot ?
						8'(is_slot_ev ? att_n : att_q[cur_idx]) : 8'd0;
					engine_mode <= eng_n;
					last        <= last_step;
					seq_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last)
							seq_q <= ST_IDLE;
						else begin
							idx_q      <= in_sweep_q ? idx_q + 1'b1 : '0;
							in_sweep_q <= 1'b1;
							seq_q      <= ST_EXEC;
						end
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		32'(c_down_q) + 32'(c_dis_q) + 32'(c_tr_q) + 32'(c_up_q) + 32'(c_rc_q)
		+ 32'(c_fail_q) <= NUM_SLOTS)
		else $error("category counts exceed slot count");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seq_q == ST_OUT)
		else $error("result shown outside output step");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == ST_IDLE && valid) |=> stall)
		else $error("accepted beat without going busy");
	a_sweep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		in_sweep_q |-> 32'(idx_q) < NUM_SLOTS)
		else $error("sweep index out of range");

endmodule
